/* hw/rtl/nearest_ansi16_colour_quantiser_core_defines.svh */
// Assertion macros shared by the colour quantiser RTL.
`ifndef NEAREST_ANSI16_COLOUR_QUANTISER_CORE_DEFINES_SVH
`define NEAREST_ANSI16_COLOUR_QUANTISER_CORE_DEFINES_SVH

// Clocked implication check, disabled while reset is asserted.
`define NAC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define NAC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `NAC_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

/* hw/rtl/nac_pkg.sv */
// Types, constants and palette functions for the nearest ANSI-16 colour quantiser.
`timescale 1ns / 1ps
`default_nettype none
package nac_pkg;

  // Squared RGB distance width: 3 * 255^2 = 195075 fits in 18 bits
  localparam int DistW   = 18;
  localparam int DistMax = 3 * 255 * 255;
  localparam int NumPal  = 16;

  // 256-colour index layout
  localparam int CubeBase = 16;
  localparam int GreyBase = 232;
  localparam int CubeSide = 6;
  localparam int CubeSq   = CubeSide * CubeSide;
  localparam int CubeOffs = 55;
  localparam int CubeStep = 40;
  localparam int GreyOffs = 8;
  localparam int GreyStep = 10;

  // Input mode codes
  localparam logic FuncRgb   = 1'b0;
  localparam logic FuncIndex = 1'b1;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } colour_t;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] colour_index;
  } in_item_t;

  // Payload handed from cell to cell: colour plus best match so far
  typedef struct packed {
    colour_t          colour;
    logic [3:0]       idx;
    logic [DistW-1:0] best_dist;
  } cell_t;

  typedef struct packed {
    logic [2:0] r;
    logic [2:0] g;
    logic [2:0] b;
  } cube_digits_t;

  // Fixed ANSI 16-colour palette
  function automatic colour_t pal_colour(input logic [3:0] idx);
    colour_t c;
    unique case (idx)
      4'd0:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
      4'd1:    c = '{r: 8'd128, g: 8'd0,   b: 8'd0};
      4'd2:    c = '{r: 8'd0,   g: 8'd128, b: 8'd0};
      4'd3:    c = '{r: 8'd128, g: 8'd128, b: 8'd0};
      4'd4:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd128};
      4'd5:    c = '{r: 8'd128, g: 8'd0,   b: 8'd128};
      4'd6:    c = '{r: 8'd0,   g: 8'd128, b: 8'd128};
      4'd7:    c = '{r: 8'd192, g: 8'd192, b: 8'd192};
      4'd8:    c = '{r: 8'd128, g: 8'd128, b: 8'd128};
      4'd9:    c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      4'd10:   c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      4'd11:   c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      4'd12:   c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      4'd13:   c = '{r: 8'd255, g: 8'd0,   b: 8'd255};
      4'd14:   c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
      default: c = '{r: 8'd255, g: 8'd255, b: 8'd255};
    endcase
    return c;
  endfunction

  // Cube axis level: 0, else 55 + 40k
  function automatic logic [7:0] cube_level(input logic [2:0] k);
    logic [7:0] v;
    if (k == 3'd0) begin
      v = 8'd0;
    end else begin
      v = 8'(CubeOffs + CubeStep * int'(k));
    end
    return v;
  endfunction

  // Split a cube offset (0..215) into base-6 digits with compare chains
  function automatic cube_digits_t cube_split(input logic [7:0] c);
    cube_digits_t d;
    logic [5:0]   rem;
    d.r = 3'd0;
    for (int k = 1; k < CubeSide; k++) begin
      if (c >= 8'(CubeSq * k)) d.r = 3'(k);
    end
    rem = 6'(c - 8'(CubeSq * int'(d.r)));
    d.g = 3'd0;
    for (int k = 1; k < CubeSide; k++) begin
      if (rem >= 6'(CubeSide * k)) d.g = 3'(k);
    end
    d.b = 3'(rem - 6'(CubeSide * int'(d.g)));
    return d;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/nac_expand.sv */
// Front stage: decodes the input mode and expands a 256-colour index to RGB.
`timescale 1ns / 1ps
`default_nettype none
module nac_expand (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire nac_pkg::in_item_t in_item_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output nac_pkg::cell_t   out_data_o
);

  logic                   valid_q;
  nac_pkg::cell_t         data_d, data_q;
  nac_pkg::cube_digits_t  digits;
  logic [7:0]             cube_off;
  logic [4:0]             grey_n;
  logic [7:0]             grey_v;

  assign in_ready_o = !valid_q || out_ready_i;

  // Index decode helpers
  assign cube_off = in_item_i.colour_index - 8'(nac_pkg::CubeBase);
  assign digits   = nac_pkg::cube_split(cube_off);
  assign grey_n   = 5'(in_item_i.colour_index - 8'(nac_pkg::GreyBase));
  assign grey_v   = 8'(nac_pkg::GreyOffs + nac_pkg::GreyStep * int'(grey_n));

  // Colour to match; distance starts above any real distance
  always_comb begin
    data_d.idx       = 4'd0;
    data_d.best_dist = '1;
    if (in_item_i.func == nac_pkg::FuncRgb) begin
      data_d.colour = '{r: in_item_i.red, g: in_item_i.green, b: in_item_i.blue};
    end else if (in_item_i.colour_index < 8'(nac_pkg::CubeBase)) begin
      data_d.colour = nac_pkg::pal_colour(in_item_i.colour_index[3:0]);
    end else if (in_item_i.colour_index < 8'(nac_pkg::GreyBase)) begin
      data_d.colour = '{r: nac_pkg::cube_level(digits.r),
                        g: nac_pkg::cube_level(digits.g),
                        b: nac_pkg::cube_level(digits.b)};
    end else begin
      data_d.colour = '{r: grey_v, g: grey_v, b: grey_v};
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

/* hw/rtl/nac_cell.sv */
// Compare cell: tests the colour against one palette entry and keeps the better match.
`timescale 1ns / 1ps
`default_nettype none
module nac_cell #(
  parameter logic [3:0] ENTRY = 4'd0
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  wire nac_pkg::cell_t in_data_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output nac_pkg::cell_t out_data_o
);

  localparam nac_pkg::colour_t Ref = nac_pkg::pal_colour(ENTRY);

  logic                           valid_q;
  nac_pkg::cell_t                 data_d, data_q;
  logic [7:0]                     diff_r, diff_g, diff_b;
  logic [nac_pkg::DistW-1:0]      sq_dist;

  assign in_ready_o = !valid_q || out_ready_i;

  // Absolute component differences
  assign diff_r = (in_data_i.colour.r > Ref.r) ? in_data_i.colour.r - Ref.r
                                               : Ref.r - in_data_i.colour.r;
  assign diff_g = (in_data_i.colour.g > Ref.g) ? in_data_i.colour.g - Ref.g
                                               : Ref.g - in_data_i.colour.g;
  assign diff_b = (in_data_i.colour.b > Ref.b) ? in_data_i.colour.b - Ref.b
                                               : Ref.b - in_data_i.colour.b;

  // Squared distance
  assign sq_dist = nac_pkg::DistW'(16'(diff_r * diff_r))
                 + nac_pkg::DistW'(16'(diff_g * diff_g))
                 + nac_pkg::DistW'(16'(diff_b * diff_b));

  // Strictly smaller wins, so the lower index keeps a tie
  always_comb begin
    data_d = in_data_i;
    if (sq_dist < in_data_i.best_dist) begin
      data_d.idx       = ENTRY;
      data_d.best_dist = sq_dist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

/* hw/rtl/nearest_ansi16_colour_quantiser_core.sv */
// Top level of the nearest ANSI-16 colour quantiser: decode stage and compare chain.
//
// Usage:
//   Slave stream: s_axis_tuser selects the mode (0 = RGB triple, 1 = 256-colour
//   index); s_axis_tdata carries red, green, blue and the colour index.
//   Master stream: one item per input item, with the nearest ANSI-16 index and
//   the colour that was matched (the input triple, or the expanded index).
//   Pipeline: one register for the mode decode and index expansion, then one
//   register per palette entry in a chain of 16 compare cells.
//   Throughput: one item per clock while the receiver takes items; every cell
//   takes a new item each cycle unless it holds an item that cannot move on.
//   Reset clears all stage valid bits; no item is in flight afterwards.
//   When the receiver stalls, the last cell holds its item and stages behind
//   it keep filling empty slots; s_axis_tready drops only once all 17 stages
//   hold items.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_ansi16_colour_quantiser_core_defines.svh"
module nearest_ansi16_colour_quantiser_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], colour_index[31:24]
  input  wire         s_axis_tuser,   // func[0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata    // nearest_index[3:0], red[11:4], green[19:12],
                                      // blue[27:20], zero[31:28]
);

  localparam int NumCells = nac_pkg::NumPal;

  nac_pkg::in_item_t in_item;
  nac_pkg::cell_t    stage_data  [NumCells+1];
  logic              stage_valid [NumCells+1];
  logic              stage_ready [NumCells+1];
  nac_pkg::cell_t    last;
  logic              dist_ok;
  logic              match_ok;
  logic              out_stall;

  // Unpack input item
  assign in_item.func         = s_axis_tuser;
  assign in_item.red          = s_axis_tdata[7:0];
  assign in_item.green        = s_axis_tdata[15:8];
  assign in_item.blue         = s_axis_tdata[23:16];
  assign in_item.colour_index = s_axis_tdata[31:24];

  // Decode and expansion stage
  nac_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (stage_valid[0]),
    .out_ready_i (stage_ready[0]),
    .out_data_o  (stage_data[0])
  );

  // Compare chain, one cell per palette entry
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    nac_cell #(
      .ENTRY (4'(i))
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stage_valid[i]),
      .in_ready_o  (stage_ready[i]),
      .in_data_i   (stage_data[i]),
      .out_valid_o (stage_valid[i+1]),
      .out_ready_i (stage_ready[i+1]),
      .out_data_o  (stage_data[i+1])
    );
  end

  // Last cell register drives the master stream
  assign last                = stage_data[NumCells];
  assign stage_ready[NumCells] = m_axis_tready;
  assign m_axis_tvalid       = stage_valid[NumCells];
  assign m_axis_tdata        = {4'd0, last.colour.b, last.colour.g, last.colour.r, last.idx};

  // Every item has passed cell 0, so its distance is a real one
  assign dist_ok   = last.best_dist <= nac_pkg::DistW'(nac_pkg::DistMax);
  // An exact match must name the palette entry of that colour
  assign match_ok  = (last.best_dist != '0) || (last.colour == nac_pkg::pal_colour(last.idx));
  // Input backs up only when the whole chain is full and the output stalls
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  `NAC_ASSERT(a_dist_range, clk_i, rst_ni, m_axis_tvalid |-> dist_ok, "distance out of range")
  `NAC_ASSERT(a_exact_match, clk_i, rst_ni, m_axis_tvalid |-> match_ok, "exact match, wrong entry")
  `NAC_ASSERT(a_backpressure, clk_i, rst_ni, !s_axis_tready |-> out_stall, "input stalled early")

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Testbench for the nearest ANSI-16 colour quantiser: stream driver, output monitor and checker.
`timescale 1ns / 1ps

// Tracks predicted matches in order and checks each output item against them
class colour_match_board;
  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } match_t;

  // ANSI palette, entry i at [i*24 +: 24] as {r, g, b}
  localparam logic [16*24-1:0] ANSI_RGB = {
    24'hFFFFFF, 24'h00FFFF, 24'hFF00FF, 24'h0000FF,
    24'hFFFF00, 24'h00FF00, 24'hFF0000, 24'h808080,
    24'hC0C0C0, 24'h008080, 24'h800080, 24'h000080,
    24'h808000, 24'h008000, 24'h800000, 24'h000000
  };

  match_t expected_q[$];
  int     errors;
  int     checked;
  int     rgb_items;
  int     index_items;

  function new();
    errors      = 0;
    checked     = 0;
    rgb_items   = 0;
    index_items = 0;
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 20) $display("tb: mismatch: %s", msg);
  endtask

  // 6x6x6 cube axis: zero, otherwise 55 + 40k
  function logic [7:0] cube_axis(int k);
    if (k == 0) return 8'd0;
    return 8'(nac_pkg::CubeOffs + nac_pkg::CubeStep * k);
  endfunction

  // Closest palette entry by squared distance; strict compare keeps the lower index on ties
  function logic [3:0] nearest_entry(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [23:0] p;
    logic [3:0]  best;
    int          best_d;
    int          dr;
    int          dg;
    int          db;
    int          d;
    best   = 4'd0;
    best_d = 32'h7FFF_FFFF;
    for (int i = 0; i < 16; i++) begin
      p  = ANSI_RGB[i*24 +: 24];
      dr = int'(r) - int'(p[23:16]);
      dg = int'(g) - int'(p[15:8]);
      db = int'(b) - int'(p[7:0]);
      d  = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best   = 4'(i);
      end
    end
    return best;
  endfunction

  function match_t quantise(logic func, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] ci);
    match_t      m;
    logic [23:0] p;
    int          c;
    int          v;
    if (func == nac_pkg::FuncRgb) begin
      m.r = r;
      m.g = g;
      m.b = b;
      m.idx = nearest_entry(r, g, b);
    end else if (int'(ci) < nac_pkg::CubeBase) begin
      // low indices take their own palette colour
      p = ANSI_RGB[int'(ci)*24 +: 24];
      m.r = p[23:16];
      m.g = p[15:8];
      m.b = p[7:0];
      m.idx = ci[3:0];
    end else begin
      if (int'(ci) < nac_pkg::GreyBase) begin
        c = int'(ci) - nac_pkg::CubeBase;
        m.r = cube_axis(c / nac_pkg::CubeSq);
        m.g = cube_axis((c / nac_pkg::CubeSide) % nac_pkg::CubeSide);
        m.b = cube_axis(c % nac_pkg::CubeSide);
      end else begin
        v = nac_pkg::GreyOffs + (int'(ci) - nac_pkg::GreyBase) * nac_pkg::GreyStep;
        m.r = 8'(v);
        m.g = 8'(v);
        m.b = 8'(v);
      end
      m.idx = nearest_entry(m.r, m.g, m.b);
    end
    return m;
  endfunction

  function void note_input(logic func, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [7:0] ci);
    if (func == nac_pkg::FuncRgb) rgb_items++;
    else index_items++;
    expected_q.push_back(quantise(func, r, g, b, ci));
  endfunction

  task check_result(logic [31:0] word);
    match_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("output item %h with nothing pending", word));
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (word[3:0] !== want.idx)
      report($sformatf("item %0d index %0d, want %0d", checked, word[3:0], want.idx));
    if (word[11:4] !== want.r)
      report($sformatf("item %0d red %0d, want %0d", checked, word[11:4], want.r));
    if (word[19:12] !== want.g)
      report($sformatf("item %0d green %0d, want %0d", checked, word[19:12], want.g));
    if (word[27:20] !== want.b)
      report($sformatf("item %0d blue %0d, want %0d", checked, word[27:20], want.b));
  endtask
endclass

module testbench;
  localparam int HoldCycles = 80;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        s_valid   = 1'b0;
  logic [31:0] s_data    = '0;
  logic        s_user    = 1'b0;
  logic        rx_ready  = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;

  // sender and receiver idling controls
  bit idling_on = 1'b1;
  int gap_pct   = 20;
  bit hold_req  = 1'b0;

  colour_match_board sb = new();

  nearest_ansi16_colour_quantiser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (rx_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one item, optionally after an idle burst; returns at the accepting edge
  task automatic offer_colour(logic func, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] ci);
    if (idling_on && $urandom_range(0, 99) < gap_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= func;
    s_data  <= {ci, b, g, r};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sb.note_input(func, r, g, b, ci);
  endtask

  // Component values biased toward palette levels and tie midpoints
  function automatic logic [7:0] pick_level();
    logic [7:0] levels [18] = '{8'd0, 8'd1, 8'd63, 8'd64, 8'd65, 8'd127, 8'd128, 8'd129,
                                8'd159, 8'd160, 8'd161, 8'd191, 8'd192, 8'd193, 8'd223,
                                8'd224, 8'd254, 8'd255};
    if ($urandom_range(0, 9) < 3) return levels[$urandom_range(0, 17)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: random stall bursts, plus one long hold when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        rx_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        rx_ready <= 1'b1;
        hold_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        rx_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        rx_ready <= 1'b1;
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  // Output monitor: values are stable at the falling edge before the accepting edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && rx_ready) sb.check_result(m_axis_tdata);
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] ci;
    logic       func;
    int         wait_cycles;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, tie points, ignored operands, every index region
    offer_colour(nac_pkg::FuncRgb, 8'd0, 8'd0, 8'd0, 8'hFF);
    offer_colour(nac_pkg::FuncRgb, 8'd255, 8'd255, 8'd255, 8'h00);
    offer_colour(nac_pkg::FuncRgb, 8'd255, 8'd0, 8'd0, 8'hA5);
    offer_colour(nac_pkg::FuncRgb, 8'd0, 8'd255, 8'd0, 8'h5A);
    offer_colour(nac_pkg::FuncRgb, 8'd0, 8'd0, 8'd255, 8'h0F);
    offer_colour(nac_pkg::FuncRgb, 8'd64, 8'd0, 8'd0, 8'h00);      // tie black / dark red
    offer_colour(nac_pkg::FuncRgb, 8'd160, 8'd160, 8'd160, 8'h00); // tie light / dark grey
    offer_colour(nac_pkg::FuncRgb, 8'd192, 8'd192, 8'd192, 8'h00);
    offer_colour(nac_pkg::FuncRgb, 8'd128, 8'd128, 8'd128, 8'h00);
    offer_colour(nac_pkg::FuncRgb, 8'd0, 8'd64, 8'd64, 8'h00);
    offer_colour(nac_pkg::FuncIndex, 8'hFF, 8'hFF, 8'hFF, 8'd0);
    offer_colour(nac_pkg::FuncIndex, 8'hAA, 8'h55, 8'hAA, 8'd7);
    offer_colour(nac_pkg::FuncIndex, 8'd0, 8'd0, 8'd0, 8'd8);
    offer_colour(nac_pkg::FuncIndex, 8'd0, 8'd0, 8'd0, 8'd9);
    offer_colour(nac_pkg::FuncIndex, 8'd0, 8'd0, 8'd0, 8'd15);
    offer_colour(nac_pkg::FuncIndex, 8'd0, 8'd0, 8'd0, 8'd16);
    offer_colour(nac_pkg::FuncIndex, 8'd0, 8'd0, 8'd0, 8'd17);
    offer_colour(nac_pkg::FuncIndex, 8'd0, 8'd0, 8'd0, 8'd100);
    offer_colour(nac_pkg::FuncIndex, 8'd0, 8'd0, 8'd0, 8'd231);
    offer_colour(nac_pkg::FuncIndex, 8'd0, 8'd0, 8'd0, 8'd232);
    offer_colour(nac_pkg::FuncIndex, 8'd0, 8'd0, 8'd0, 8'd244);
    offer_colour(nac_pkg::FuncIndex, 8'd0, 8'd0, 8'd0, 8'd255);

    // Long output hold while items keep coming back to back
    idling_on = 1'b0;
    hold_req  = 1'b1;
    for (int n = 0; n < 60; n++) begin
      offer_colour(1'($urandom_range(0, 1)), pick_level(), pick_level(), pick_level(),
                   8'($urandom_range(0, 255)));
    end
    idling_on = 1'b1;

    // Random traffic; idling density changes per segment, none at the tail
    for (int n = 0; n < 1520; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 45;
        endcase
      end
      if (n == 1320) idling_on = 1'b0;
      func = 1'($urandom_range(0, 1));
      r    = pick_level();
      g    = pick_level();
      b    = pick_level();
      ci   = 8'($urandom_range(0, 255));
      offer_colour(func, r, g, b, ci);
    end
    s_valid <= 1'b0;

    // Drain the pipeline
    wait_cycles = 0;
    while (sb.expected_q.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (40) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

    $display("tb: %0d RGB items and %0d palette index items, %0d results compared",
             sb.rgb_items, sb.index_items, sb.checked);
    $display("tb: included tie points, all index regions and an %0d-cycle output hold",
             HoldCycles);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/nac_pkg.sv
hw/rtl/nac_expand.sv
hw/rtl/nac_cell.sv
hw/rtl/nearest_ansi16_colour_quantiser_core.sv
sim/testbench.sv
